// ===== rtl/ehet_pkg.sv =====
// Package for the excess heterozygosity exact test block.
// Holds widths, fixed-point constants and the request structs of the shared units.
// No dependencies.
package ehet_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int CNT_W       = 11;
    localparam int N_W         = 13;
    localparam int H_W         = 12;
    localparam int FRAC_BITS   = 56;
    localparam int P_W         = 64;
    localparam int AB_W        = 24;
    localparam int PROD_W      = P_W + AB_W;
    localparam int DIV_W       = 121;
    localparam int DCNT_W      = 7;
    localparam int PH_W        = 16;
    localparam int RAW_W       = FRAC_BITS + 1;

    localparam logic [P_W-1:0]    ONE_Q56      = 64'h0100_0000_0000_0000;
    localparam logic [P_W-1:0]    MIN_TERM_RAW = 64'd73;
    localparam logic [PH_W-1:0]   CAP_PHRED    = 16'd40960;
    localparam logic [25:0]       K_PHRED_Q16  = 26'd50504453;
    localparam logic [DCNT_W-1:0] MUL_DIV_BITS = 7'd88;
    localparam logic [DCNT_W-1:0] FRAC_DIV_BITS = 7'd121;
    localparam logic [DCNT_W-1:0] MID_DIV_BITS = 7'd24;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  num;
        logic [P_W-1:0]    den;
        logic [DCNT_W-1:0] bits;
    } t_div_req;

    typedef struct packed {
        logic            start;
        logic [P_W-1:0]  mcand;
        logic [AB_W-1:0] mplier;
    } t_mul_req;

    function automatic logic [P_W-1:0] sat_add(input logic [P_W-1:0] x, input logic [P_W-1:0] y);
        logic [P_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[P_W] ? {P_W{1'b1}} : s[P_W-1:0];
    endfunction

endpackage

// ===== rtl/ehet_mul.sv =====
// Serial shift-add multiplier, one multiplier bit per cycle.
// Depends on ehet_pkg.
module ehet_mul
    import ehet_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mul_req          i_req,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);
    logic [PROD_W-1:0] r_acc, n_acc, r_mcand, n_mcand;
    logic [AB_W-1:0]   r_mplier, n_mplier;
    logic [4:0]        r_cnt, n_cnt;
    logic              r_busy, n_busy, r_done, n_done;

    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_req.start) begin
            n_acc    = '0;
            n_mcand  = {{AB_W{1'b0}}, i_req.mcand};
            n_mplier = i_req.mplier;
            n_cnt    = 5'(AB_W);
            n_busy   = 1'b1;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_cnt    <= n_cnt;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ===== rtl/ehet_div.sv =====
// Serial restoring divider, one quotient bit per cycle, MSB-aligned dividend.
// Depends on ehet_pkg.
module ehet_div
    import ehet_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quo
);
    logic [DIV_W-1:0]  r_num, n_num, r_quo, n_quo;
    logic [P_W-1:0]    r_rem, n_rem, r_den, n_den;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy, r_done, n_done;
    logic [P_W:0]      trial;
    logic              ge;

    always_comb begin
        trial  = {r_rem, r_num[DIV_W-1]};
        ge     = trial >= {1'b0, r_den};
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_num  = i_req.num;
            n_den  = i_req.den;
            n_rem  = '0;
            n_quo  = '0;
            n_cnt  = i_req.bits;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = ge ? P_W'(trial - {1'b0, r_den}) : trial[P_W-1:0];
            n_quo  = {r_quo[DIV_W-2:0], ge};
            n_num  = r_num << 1;
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == DCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== rtl/ehet_log.sv =====
// Phred conversion: normalize, log2 by repeated squaring, scale and round.
// Depends on ehet_pkg.
module ehet_log
    import ehet_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RAW_W-1:0] i_raw,
    output logic             o_done,
    output logic [PH_W-1:0]  o_phred
);
    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_NORM = 6'b000010,
        L_SQM  = 6'b000100,
        L_SQA  = 6'b001000,
        L_FMUL = 6'b010000,
        L_FRND = 6'b100000
    } t_lstate;

    t_lstate           r_st, n_st;
    logic [RAW_W-1:0]  r_x, n_x;
    logic [5:0]        r_e, n_e;
    logic [31:0]       r_m, n_m;
    logic [63:0]       r_sq, n_sq;
    logic [23:0]       r_frac, n_frac;
    logic [4:0]        r_i, n_i;
    logic [55:0]       r_prod, n_prod;
    logic [PH_W-1:0]   r_ph, n_ph;
    logic              r_done, n_done;
    logic [32:0]       t;
    logic [29:0]       l2, d;
    logic [40:0]       v;

    localparam logic [29:0] D_FULL = 30'(FRAC_BITS) << 24;

    always_comb begin
        n_st   = r_st;
        n_x    = r_x;
        n_e    = r_e;
        n_m    = r_m;
        n_sq   = r_sq;
        n_frac = r_frac;
        n_i    = r_i;
        n_prod = r_prod;
        n_ph   = r_ph;
        n_done = 1'b0;
        t      = r_sq[63:31];
        l2     = {r_e, r_frac};
        d      = (l2 >= D_FULL) ? '0 : D_FULL - l2;
        v      = 41'({1'b0, r_prod[55:40]}) + 41'(r_prod[39]);
        unique case (r_st)
            L_IDLE: begin
                if (i_start) begin
                    n_x  = i_raw;
                    n_e  = 6'(FRAC_BITS);
                    n_st = L_NORM;
                end
            end
            L_NORM: begin
                if (r_x[RAW_W-1]) begin
                    n_m    = r_x[RAW_W-1 -: 32];
                    n_frac = '0;
                    n_i    = 5'd23;
                    n_st   = L_SQM;
                end else begin
                    n_x = r_x << 1;
                    n_e = r_e - 6'd1;
                end
            end
            L_SQM: begin
                n_sq = 64'(r_m) * 64'(r_m);
                n_st = L_SQA;
            end
            L_SQA: begin
                n_m    = t[32] ? t[32:1] : t[31:0];
                n_frac = {r_frac[22:0], t[32]};
                n_i    = r_i - 5'd1;
                n_st   = (r_i == 5'd0) ? L_FMUL : L_SQM;
            end
            L_FMUL: begin
                n_prod = 56'(d) * 56'(K_PHRED_Q16);
                n_st   = L_FRND;
            end
            L_FRND: begin
                n_ph   = (v > 41'd65535) ? {PH_W{1'b1}} : v[PH_W-1:0];
                n_done = 1'b1;
                n_st   = L_IDLE;
            end
            default: n_st = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_x    <= n_x;
        r_e    <= n_e;
        r_m    <= n_m;
        r_sq   <= n_sq;
        r_frac <= n_frac;
        r_i    <= n_i;
        r_prod <= n_prod;
        r_ph   <= n_ph;
    end

    assign o_done  = r_done;
    assign o_phred = r_ph;
endmodule

// ===== rtl/excess_het_exact_test.sv =====
// Excess heterozygosity exact test: one site per transaction, one result per transaction.
// Each probability term takes a serial multiply followed by a serial divide and
// bookkeeping; then the tail fraction is divided out and converted to phred. A site
// has at most 513 terms for 1024 samples.
// Count overflow skips the computation. The input stalls while an item is in progress;
// a finished result waits in the output register while the next transaction is taken.
// Depends on ehet_pkg, ehet_mul, ehet_div and ehet_log.
module excess_het_exact_test
    import ehet_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CNT_W-1:0] i_het_number,
    input  logic [CNT_W-1:0] i_refhom_number,
    input  logic [CNT_W-1:0] i_althom_number,
    input  logic [CNT_W-1:0] i_called_samples,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PH_W-1:0]  o_phred_score,
    output logic             o_has_samples,
    output logic             o_count_error
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PRE   = 11'b00000000010,
        S_MID   = 11'b00000000100,
        S_FIX   = 11'b00000001000,
        S_STEP  = 11'b00000010000,
        S_MUL   = 11'b00000100000,
        S_DIV   = 11'b00001000000,
        S_UPINI = 11'b00010000000,
        S_FRAC  = 11'b00100000000,
        S_FWAIT = 11'b01000000000,
        S_LOG   = 11'b10000000000
    } t_state;

    t_state           r_state, n_state;
    logic             r_fin, n_fin;
    logic [CNT_W-1:0] r_het, n_het;
    logic [N_W-1:0]   r_n, n_n, r_rare, n_rare;
    logic             r_has, n_has, r_err, n_err;
    logic [H_W-1:0]   r_mid, n_mid, r_r0, n_r0, r_c0, n_c0;
    logic [H_W-1:0]   r_h, n_h, r_r, n_r, r_c, n_c;
    logic             r_up, n_up;
    logic [P_W-1:0]   r_p, n_p, r_sum, n_sum, r_tail, n_tail;
    logic [AB_W-1:0]  r_b, n_b;
    logic [PH_W-1:0]  r_phred, n_phred;
    logic             r_o_valid, n_o_valid;
    logic [PH_W-1:0]  r_o_phred, n_o_phred;
    logic             r_o_has, n_o_has, r_o_err, n_o_err;

    t_div_req          div_req;
    t_mul_req          mul_req;
    logic              div_done, mul_done, log_start, log_done;
    logic [DIV_W-1:0]  div_quo;
    logic [PROD_W-1:0] mul_prod;
    logic [PH_W-1:0]   log_phred;

    logic [CNT_W-1:0]  min_hom;
    logic [N_W-1:0]    two_n, m1, m2, rr, h_up;
    logic [N_W:0]      cc;
    logic [23:0]       mid_num;
    logic [P_W-1:0]    term, tl;
    logic              out_free;
    logic [N_W-1:0]    idx;

    ehet_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    ehet_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    ehet_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_raw   (div_quo[RAW_W-1:0]),
        .o_done  (log_done),
        .o_phred (log_phred)
    );

    always_comb begin
        n_state   = r_state;
        n_fin     = r_fin;
        n_het     = r_het;
        n_n       = r_n;
        n_rare    = r_rare;
        n_has     = r_has;
        n_err     = r_err;
        n_mid     = r_mid;
        n_r0      = r_r0;
        n_c0      = r_c0;
        n_h       = r_h;
        n_r       = r_r;
        n_c       = r_c;
        n_up      = r_up;
        n_p       = r_p;
        n_sum     = r_sum;
        n_tail    = r_tail;
        n_b       = r_b;
        n_phred   = r_phred;
        n_o_phred = r_o_phred;
        n_o_has   = r_o_has;
        n_o_err   = r_o_err;
        log_start = 1'b0;

        out_free  = !r_o_valid || !i_stall;
        n_o_valid = r_o_valid && i_stall;

        min_hom = (i_refhom_number < i_althom_number) ? i_refhom_number : i_althom_number;
        two_n   = r_n << 1;
        mid_num = 24'(r_rare[H_W-1:0]) * 24'(H_W'(two_n - r_rare));
        m1      = r_mid + N_W'(r_mid[0] != r_rare[0]);
        m2      = (m1 > r_rare) ? r_rare : m1;
        rr      = (r_rare - m2) >> 1;
        cc      = {1'b0, r_n} - {1'b0, m2} - {1'b0, rr};
        h_up    = N_W'(r_h) + N_W'(2);
        term    = (|div_quo[DIV_W-1:P_W]) ? {P_W{1'b1}} : div_quo[P_W-1:0];
        tl      = (r_tail > r_sum) ? r_sum : r_tail;
        idx     = r_up ? h_up : N_W'(r_h) - N_W'(2);

        div_req = '0;
        mul_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_het   = i_het_number;
                    n_n     = N_W'(i_het_number) + N_W'(i_refhom_number)
                            + N_W'(i_althom_number);
                    n_rare  = (N_W'(min_hom) << 1) + N_W'(i_het_number);
                    n_has   = i_called_samples != '0;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                if (r_n > N_W'(MAX_SAMPLES)) begin
                    n_err   = 1'b1;
                    n_phred = '0;
                    n_fin   = 1'b1;
                end else if (r_n == '0) begin
                    n_err   = 1'b0;
                    n_mid   = '0;
                    n_state = S_FIX;
                end else begin
                    n_err         = 1'b0;
                    div_req.start = 1'b1;
                    div_req.num   = {mid_num, {(DIV_W-24){1'b0}}};
                    div_req.den   = P_W'(two_n - N_W'(1));
                    div_req.bits  = MID_DIV_BITS;
                    n_state       = S_MID;
                end
            end
            S_MID: begin
                if (div_done) begin
                    n_mid   = div_quo[H_W-1:0];
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_mid   = m2[H_W-1:0];
                n_h     = m2[H_W-1:0];
                n_r     = rr[H_W-1:0];
                n_c     = cc[N_W] ? '0 : cc[H_W-1:0];
                n_r0    = rr[H_W-1:0];
                n_c0    = cc[N_W] ? '0 : cc[H_W-1:0];
                n_p     = ONE_Q56;
                n_sum   = ONE_Q56;
                n_tail  = (m2 >= N_W'(r_het)) ? ONE_Q56 : '0;
                n_up    = 1'b0;
                n_state = S_STEP;
            end
            S_STEP: begin
                if (!r_up) begin
                    if (r_h < H_W'(2)) begin
                        n_state = S_UPINI;
                    end else begin
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = r_p;
                        mul_req.mplier = AB_W'(r_h) * AB_W'(r_h - H_W'(1));
                        n_b            = AB_W'(AB_W'(r_r + H_W'(1)) * AB_W'(r_c + H_W'(1)) << 2);
                        n_state        = S_MUL;
                    end
                end else begin
                    if (h_up > r_rare) begin
                        n_state = S_FRAC;
                    end else begin
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = r_p;
                        mul_req.mplier = AB_W'(AB_W'(r_r) * AB_W'(r_c) << 2);
                        n_b            = AB_W'(h_up) * AB_W'(r_h + H_W'(1));
                        n_state        = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    div_req.start = 1'b1;
                    div_req.num   = {mul_prod, {(DIV_W-PROD_W){1'b0}}};
                    div_req.den   = P_W'(r_b);
                    div_req.bits  = MUL_DIV_BITS;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (term < MIN_TERM_RAW) begin
                        n_state = r_up ? S_FRAC : S_UPINI;
                    end else begin
                        n_p   = term;
                        n_sum = sat_add(r_sum, term);
                        if (idx >= N_W'(r_het)) begin
                            n_tail = sat_add(r_tail, term);
                        end
                        n_h = idx[H_W-1:0];
                        if (r_up) begin
                            n_r = (r_r == '0) ? '0 : r_r - H_W'(1);
                            n_c = (r_c == '0) ? '0 : r_c - H_W'(1);
                        end else begin
                            n_r = r_r + H_W'(1);
                            n_c = r_c + H_W'(1);
                        end
                        n_state = S_STEP;
                    end
                end
            end
            S_UPINI: begin
                n_h     = r_mid;
                n_r     = r_r0;
                n_c     = r_c0;
                n_p     = ONE_Q56;
                n_up    = 1'b1;
                n_state = S_STEP;
            end
            S_FRAC: begin
                div_req.start = 1'b1;
                div_req.num   = {1'b0, tl, {FRAC_BITS{1'b0}}};
                div_req.den   = r_sum;
                div_req.bits  = FRAC_DIV_BITS;
                n_state       = S_FWAIT;
            end
            S_FWAIT: begin
                if (div_done) begin
                    if (div_quo == '0) begin
                        n_phred = CAP_PHRED;
                        n_fin   = 1'b1;
                    end else begin
                        log_start = 1'b1;
                        n_state   = S_LOG;
                    end
                end
            end
            S_LOG: begin
                if (log_done) begin
                    n_phred = log_phred;
                    n_fin   = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (r_fin) begin
            n_fin = 1'b1;
            if (out_free) begin
                n_o_valid = 1'b1;
                n_o_phred = r_phred;
                n_o_has   = r_has;
                n_o_err   = r_err;
                n_fin     = 1'b0;
                n_state   = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fin     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fin     <= n_fin;
            r_o_valid <= n_o_valid;
        end
        r_het     <= n_het;
        r_n       <= n_n;
        r_rare    <= n_rare;
        r_has     <= n_has;
        r_err     <= n_err;
        r_mid     <= n_mid;
        r_r0      <= n_r0;
        r_c0      <= n_c0;
        r_h       <= n_h;
        r_r       <= n_r;
        r_c       <= n_c;
        r_up      <= n_up;
        r_p       <= n_p;
        r_sum     <= n_sum;
        r_tail    <= n_tail;
        r_b       <= n_b;
        r_phred   <= n_phred;
        r_o_phred <= n_o_phred;
        r_o_has   <= n_o_has;
        r_o_err   <= n_o_err;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_phred_score = r_o_phred;
    assign o_has_samples = r_o_has;
    assign o_count_error = r_o_err;
endmodule

// ===== dv/testbench.sv =====
// Testbench for excess_het_exact_test: drives genotype count transactions and checks
// the phred score and flags against a scoreboard class with its own exact-test predictor.
// Depends on ehet_pkg and the excess_het_exact_test RTL.
module testbench
    import ehet_pkg::*;
();

    localparam int  STORE_N     = 2 * MAX_SAMPLES + 1;
    localparam longint CYCLE_LIMIT = 40_000_000;

    typedef struct {
        logic [PH_W-1:0] phred;
        logic            has_samples;
        logic            count_error;
    } t_site_result;

    class hwe_scoreboard;
        bit [63:0]    prob_tab[STORE_N];
        t_site_result expected_q[$];
        int           mismatches;
        int           sites_in;
        int           sites_out;
        int           overflow_sites;
        int           capped_sites;

        function new();
            mismatches = 0;
            sites_in = 0;
            sites_out = 0;
            overflow_sites = 0;
            capped_sites = 0;
        endfunction

        function bit [63:0] add_sat(bit [63:0] x, bit [63:0] y);
            bit [64:0] s;
            s = {1'b0, x} + {1'b0, y};
            return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
        endfunction

        function bit [63:0] scale_term(bit [63:0] p, bit [63:0] a, bit [63:0] b);
            bit [63:0] q, r;
            if (b == 0 || a == 0) return 0;
            q = p / b;
            r = p % b;
            if (q > 64'hFFFF_FFFF_FFFF_FFFF / a) return 64'hFFFF_FFFF_FFFF_FFFF;
            return add_sat(q * a, (r * a) / b);
        endfunction

        function bit [63:0] tail_fraction(bit [63:0] n, bit [63:0] d);
            bit [63:0] q, rem;
            bit        top;
            q = 0;
            rem = n;
            if (d == 0) return 0;
            if (rem >= d) begin
                q = 1;
                rem = rem - d;
            end
            for (int i = 0; i < FRAC_BITS; i++) begin
                top = rem[63];
                rem = rem << 1;
                q = q << 1;
                if (top || rem >= d) begin
                    rem = rem - d;
                    q[0] = 1'b1;
                end
            end
            return q;
        endfunction

        function bit [15:0] phred_256(bit [63:0] raw);
            int unsigned e;
            bit [63:0]   m, l2, d, v;
            e = 0;
            while (e < 63 && (raw >> (e + 1)) != 0) e++;
            if (e >= 31) m = raw >> (e - 31);
            else m = raw << (31 - e);
            l2 = 64'(e) << 24;
            for (int i = 23; i >= 0; i--) begin
                m = (m * m) >> 31;
                if (m >= 64'h1_0000_0000) begin
                    m = m >> 1;
                    l2[i] = 1'b1;
                end
            end
            d = 64'(FRAC_BITS) << 24;
            d = (l2 >= d) ? 64'd0 : d - l2;
            v = (d * 64'(K_PHRED_Q16) + (64'd1 << 39)) >> 40;
            return (v > 65535) ? 16'hFFFF : v[15:0];
        endfunction

        function t_site_result predict_site(int het, int rh, int ah, int called);
            t_site_result res;
            longint       n, rare, mid, h, r, c;
            bit [63:0]    sum, tail, pval, p;
            n = het + rh + ah;
            res.has_samples = (called >= 1);
            res.count_error = 1'b0;
            res.phred = '0;
            if (n > MAX_SAMPLES) begin
                res.count_error = 1'b1;
                overflow_sites++;
                return res;
            end
            foreach (prob_tab[i]) prob_tab[i] = 0;
            rare = 2 * ((rh < ah) ? rh : ah) + het;
            if (n == 0) mid = 0;
            else mid = (rare * (2 * n - rare)) / (2 * n - 1);
            if ((mid & 1) != (rare & 1)) mid++;
            if (mid > rare) mid = rare;
            if (mid < 0) mid = 0;
            prob_tab[mid] = ONE_Q56;
            sum = ONE_Q56;
            h = mid;
            r = (rare - mid) / 2;
            c = n - h - r;
            if (c < 0) c = 0;
            while (h >= 2) begin
                p = scale_term(prob_tab[h], 64'(h * (h - 1)), 64'(4 * (r + 1) * (c + 1)));
                if (p < MIN_TERM_RAW) break;
                prob_tab[h - 2] = p;
                sum = add_sat(sum, p);
                h -= 2;
                r++;
                c++;
            end
            h = mid;
            r = (rare - mid) / 2;
            c = n - h - r;
            if (c < 0) c = 0;
            while (h + 2 <= rare) begin
                p = scale_term(prob_tab[h], 64'(4 * r * c), 64'((h + 2) * (h + 1)));
                if (p < MIN_TERM_RAW) break;
                prob_tab[h + 2] = p;
                sum = add_sat(sum, p);
                h += 2;
                r--;
                c--;
                if (r < 0) r = 0;
                if (c < 0) c = 0;
            end
            tail = 0;
            for (longint k = het; k <= rare && k < STORE_N; k++)
                tail = add_sat(tail, prob_tab[k]);
            if (tail > sum) tail = sum;
            pval = tail_fraction(tail, sum);
            if (pval == 0) begin
                res.phred = CAP_PHRED;
                capped_sites++;
            end else begin
                res.phred = phred_256(pval);
            end
            return res;
        endfunction

        function void note_site(int het, int rh, int ah, int called);
            expected_q.push_back(predict_site(het, rh, ah, called));
            sites_in++;
        endfunction

        function void check_result(logic [PH_W-1:0] ph, logic hs, logic ce);
            t_site_result exp_r;
            sites_out++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: phred=%0d has=%0b err=%0b", ph, hs, ce);
                return;
            end
            exp_r = expected_q.pop_front();
            if (ph !== exp_r.phred || hs !== exp_r.has_samples || ce !== exp_r.count_error) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d exp/got: phred %0d/%0d has %0b/%0b err %0b/%0b",
                             sites_out, exp_r.phred, ph, exp_r.has_samples, hs,
                             exp_r.count_error, ce);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [CNT_W-1:0] i_het_number;
    logic [CNT_W-1:0] i_refhom_number;
    logic [CNT_W-1:0] i_althom_number;
    logic [CNT_W-1:0] i_called_samples;
    logic             o_valid;
    logic             i_stall;
    logic [PH_W-1:0]  o_phred_score;
    logic             o_has_samples;
    logic             o_count_error;

    hwe_scoreboard sb;
    bit            quiet;
    bit            hold_req;
    bit            hold_done;
    longint        cycles = 0;

    excess_het_exact_test uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_het_number     (i_het_number),
        .i_refhom_number  (i_refhom_number),
        .i_althom_number  (i_althom_number),
        .i_called_samples (i_called_samples),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_phred_score    (o_phred_score),
        .o_has_samples    (o_has_samples),
        .o_count_error    (o_count_error)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_site(i_het_number, i_refhom_number, i_althom_number, i_called_samples);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_phred_score, o_has_samples, o_count_error);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[excess_het_exact_test] ERROR");
            $finish;
        end
    end

    // receiver: random stall, quiet stretch, one long hold-off
    initial begin
        hold_done = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= !quiet && ($urandom_range(99) < 18);
            end
        end
    end

    task automatic send_site(int het, int rh, int ah, int called);
        if (!quiet && $urandom_range(99) < 18) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_het_number     <= CNT_W'(het);
        i_refhom_number  <= CNT_W'(rh);
        i_althom_number  <= CNT_W'(ah);
        i_called_samples <= CNT_W'(called);
        i_valid          <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
    endtask

    task automatic send_random_site();
        int sel, lim, het, rh, ah;
        sel = $urandom_range(99);
        if (sel < 10) begin
            send_site($urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                      $urandom_range(2047));
            return;
        end
        lim = (sel < 13) ? MAX_SAMPLES : 48;
        het = $urandom_range(lim);
        rh  = $urandom_range(lim - het);
        ah  = $urandom_range(lim - het - rh);
        if ($urandom_range(1)) send_site(het, ah, rh, $urandom_range(2047));
        else send_site(het, rh, ah, het + rh + ah);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        quiet = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_het_number = '0;
        i_refhom_number = '0;
        i_althom_number = '0;
        i_called_samples = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_site(0, 0, 0, 0);
        send_site(0, 0, 0, 2047);
        send_site(1024, 0, 0, 1024);
        send_site(0, 1024, 0, 1024);
        send_site(0, 0, 1024, 1024);
        send_site(512, 256, 256, 1024);
        send_site(2047, 2047, 2047, 2047);
        send_site(1024, 1, 0, 1);
        send_site(1, 1024, 0, 0);
        send_site(341, 342, 341, 1024);
        send_site(200, 0, 0, 200);
        send_site(0, 100, 100, 200);
        send_site(1, 0, 0, 1);
        send_site(0, 1, 0, 1);
        send_site(2, 3, 1, 6);
        send_site(1, 0, 1024, 1025);
        send_site(40, 5, 3, 1365);
        send_site(0, 0, 1, 682);
        drain();

        quiet = 1'b1;
        repeat (30) send_random_site();
        quiet = 1'b0;

        hold_req = 1'b1;
        repeat (8) send_site($urandom_range(12), $urandom_range(12), $urandom_range(12), 5);
        drain();

        repeat (62) send_random_site();
        drain();

        $display("covered %0d sites (%0d over the count limit, %0d capped), %0d results",
                 sb.sites_in, sb.overflow_sites, sb.capped_sites, sb.sites_out);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[excess_het_exact_test] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
            $display("[excess_het_exact_test] ERROR");
        end
        $finish;
    end
endmodule
